// ===== rtl/rsfp_pkg.sv =====
// rsfp_pkg: shared types, codes and field tables of the frame parser
// no dependencies; used by every other file of the block except rsfp_ifs
package rsfp_pkg;

  // frame types that carry fixed fields
  localparam logic [5:0] T_SETUP       = 6'h01;
  localparam logic [5:0] T_KEEPALIVE   = 6'h03;
  localparam logic [5:0] T_REQ_STREAM  = 6'h06;
  localparam logic [5:0] T_REQ_CHANNEL = 6'h07;
  localparam logic [5:0] T_REQ_N       = 6'h08;
  localparam logic [5:0] T_ERROR       = 6'h0B;

  // flag bits of the type/flags word
  localparam logic [15:0] FLAG_METADATA = 16'h0100;
  localparam logic [15:0] FLAG_RESUME   = 16'h0080;

  localparam logic [23:0] PREFIX_BYTES = 24'd3;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TRUNC  = 2'd1;
  localparam logic [1:0] ERR_PREFIX = 2'd2;

  // field codes as seen on the output
  localparam logic [4:0] FC_LEN        = 5'd0;
  localparam logic [4:0] FC_STREAM     = 5'd1;
  localparam logic [4:0] FC_TYPE       = 5'd2;
  localparam logic [4:0] FC_MAJOR      = 5'd3;
  localparam logic [4:0] FC_MINOR      = 5'd4;
  localparam logic [4:0] FC_KEEPALIVE  = 5'd5;
  localparam logic [4:0] FC_LIFETIME   = 5'd6;
  localparam logic [4:0] FC_RTOK_LEN   = 5'd7;
  localparam logic [4:0] FC_RTOK       = 5'd8;
  localparam logic [4:0] FC_MMIME_LEN  = 5'd9;
  localparam logic [4:0] FC_MMIME      = 5'd10;
  localparam logic [4:0] FC_DMIME_LEN  = 5'd11;
  localparam logic [4:0] FC_DMIME      = 5'd12;
  localparam logic [4:0] FC_POSITION   = 5'd13;
  localparam logic [4:0] FC_COUNT      = 5'd14;
  localparam logic [4:0] FC_ERRCODE    = 5'd15;
  localparam logic [4:0] FC_MD_LEN     = 5'd16;
  localparam logic [4:0] FC_MD         = 5'd17;
  localparam logic [4:0] FC_DATA       = 5'd18;

  // parse position, one-hot
  typedef enum logic [18:0] {
    POS_LEN       = 19'h00001,
    POS_STREAM    = 19'h00002,
    POS_TYPE      = 19'h00004,
    POS_MAJOR     = 19'h00008,
    POS_MINOR     = 19'h00010,
    POS_KEEPALIVE = 19'h00020,
    POS_LIFETIME  = 19'h00040,
    POS_RTOK_LEN  = 19'h00080,
    POS_RTOK      = 19'h00100,
    POS_MMIME_LEN = 19'h00200,
    POS_MMIME     = 19'h00400,
    POS_DMIME_LEN = 19'h00800,
    POS_DMIME     = 19'h01000,
    POS_POSITION  = 19'h02000,
    POS_COUNT     = 19'h04000,
    POS_ERRCODE   = 19'h08000,
    POS_MD_LEN    = 19'h10000,
    POS_MD        = 19'h20000,
    POS_DATA      = 19'h40000
  } pos_t;

  // one accepted input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_capture;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [4:0] field_code;
    logic [7:0] byte_out;
    logic [5:0] frame_kind;
    logic       field_last;
    logic       frame_last;
    logic [1:0] fault_code;
  } result_t;

  function automatic logic [4:0] pos_code(input pos_t p);
    logic [4:0] c;
    case (p)
      POS_LEN:       c = FC_LEN;
      POS_STREAM:    c = FC_STREAM;
      POS_TYPE:      c = FC_TYPE;
      POS_MAJOR:     c = FC_MAJOR;
      POS_MINOR:     c = FC_MINOR;
      POS_KEEPALIVE: c = FC_KEEPALIVE;
      POS_LIFETIME:  c = FC_LIFETIME;
      POS_RTOK_LEN:  c = FC_RTOK_LEN;
      POS_RTOK:      c = FC_RTOK;
      POS_MMIME_LEN: c = FC_MMIME_LEN;
      POS_MMIME:     c = FC_MMIME;
      POS_DMIME_LEN: c = FC_DMIME_LEN;
      POS_DMIME:     c = FC_DMIME;
      POS_POSITION:  c = FC_POSITION;
      POS_COUNT:     c = FC_COUNT;
      POS_ERRCODE:   c = FC_ERRCODE;
      POS_MD_LEN:    c = FC_MD_LEN;
      POS_MD:        c = FC_MD;
      default:       c = FC_DATA;
    endcase
    return c;
  endfunction

  // length-delimited body fields
  function automatic logic is_body(input pos_t p);
    return (p == POS_RTOK) || (p == POS_MMIME) || (p == POS_DMIME) || (p == POS_MD);
  endfunction

  // byte size of fixed fields
  function automatic logic [3:0] fixed_size(input pos_t p);
    logic [3:0] s;
    case (p)
      POS_LEN:       s = 4'd3;
      POS_STREAM:    s = 4'd4;
      POS_TYPE:      s = 4'd2;
      POS_MAJOR:     s = 4'd2;
      POS_MINOR:     s = 4'd2;
      POS_KEEPALIVE: s = 4'd4;
      POS_LIFETIME:  s = 4'd4;
      POS_RTOK_LEN:  s = 4'd2;
      POS_MMIME_LEN: s = 4'd1;
      POS_DMIME_LEN: s = 4'd1;
      POS_POSITION:  s = 4'd8;
      POS_COUNT:     s = 4'd4;
      POS_ERRCODE:   s = 4'd4;
      POS_MD_LEN:    s = 4'd3;
      default:       s = 4'd0;
    endcase
    return s;
  endfunction

  // field that follows p in the current frame
  function automatic pos_t next_of(input pos_t p, input logic [5:0] ftype,
                                   input logic meta, input logic resume);
    pos_t tail;
    pos_t n;
    tail = meta ? POS_MD_LEN : POS_DATA;
    case (p)
      POS_LEN:    n = POS_STREAM;
      POS_STREAM: n = POS_TYPE;
      POS_TYPE: begin
        if (ftype == T_SETUP) n = POS_MAJOR;
        else if (ftype == T_KEEPALIVE) n = POS_POSITION;
        else if (ftype == T_REQ_STREAM || ftype == T_REQ_CHANNEL || ftype == T_REQ_N)
          n = POS_COUNT;
        else if (ftype == T_ERROR) n = POS_ERRCODE;
        else n = tail;
      end
      POS_MAJOR:     n = POS_MINOR;
      POS_MINOR:     n = POS_KEEPALIVE;
      POS_KEEPALIVE: n = POS_LIFETIME;
      POS_LIFETIME:  n = resume ? POS_RTOK_LEN : POS_MMIME_LEN;
      POS_RTOK_LEN:  n = POS_RTOK;
      POS_RTOK:      n = POS_MMIME_LEN;
      POS_MMIME_LEN: n = POS_MMIME;
      POS_MMIME:     n = POS_DMIME_LEN;
      POS_DMIME_LEN: n = POS_DMIME;
      POS_MD_LEN:    n = POS_MD;
      POS_DMIME:     n = tail;
      POS_POSITION:  n = tail;
      POS_COUNT:     n = tail;
      POS_ERRCODE:   n = tail;
      default:       n = POS_DATA;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/rsfp_ifs.sv =====
// rsfp_byte_if and rsfp_field_if: valid/ready channels of the frame parser
// no dependencies
interface rsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_capture;

  modport source(output valid, output data_byte, output end_of_capture, input ready);
  modport sink(input valid, input data_byte, input end_of_capture, output ready);
endinterface

interface rsfp_field_if;
  logic       valid;
  logic       ready;
  logic [4:0] field_code;
  logic [7:0] byte_out;
  logic [5:0] frame_kind;
  logic       field_last;
  logic       frame_last;
  logic [1:0] fault_code;

  modport source(output valid, output field_code, output byte_out, output frame_kind,
                 output field_last, output frame_last, output fault_code, input ready);
  modport sink(input valid, input field_code, input byte_out, input frame_kind,
               input field_last, input frame_last, input fault_code, output ready);
endinterface

// ===== rtl/rsfp_in_stage.sv =====
// rsfp_in_stage: input register of the frame parser, holds one beat
// depends on rsfp_pkg and rsfp_byte_if
module rsfp_in_stage (
  input  logic               clk,
  input  logic               rst,
  rsfp_byte_if.sink          raw_bytes,
  input  logic               take,
  output logic               hold_valid,
  output rsfp_pkg::beat_t    item
);

  assign raw_bytes.ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (raw_bytes.ready) begin
      hold_valid <= raw_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_bytes.valid && raw_bytes.ready) begin
      item.data_byte      <= raw_bytes.data_byte;
      item.end_of_capture <= raw_bytes.end_of_capture;
    end
  end

endmodule

// ===== rtl/rsfp_field_engine.sv =====
// rsfp_field_engine: parse state and per-byte field tagging logic
// depends on rsfp_pkg
module rsfp_field_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data,
  input  logic               step,
  input  rsfp_pkg::beat_t    item,
  output rsfp_pkg::result_t  result
);

  logic               length_prefix_enable;
  logic               prefix_mode;
  rsfp_pkg::pos_t     parse_position;
  logic [23:0]        field_byte_count;
  logic [23:0]        frame_bytes_left;
  logic [5:0]         current_type;
  logic               resume_seen;
  logic               metadata_seen;
  logic [23:0]        len_acc;

  logic               prefix_mode_next;
  rsfp_pkg::pos_t     parse_position_next;
  logic [23:0]        field_byte_count_next;
  logic [23:0]        frame_bytes_left_next;
  logic [5:0]         current_type_next;
  logic               resume_seen_next;
  logic               metadata_seen_next;
  logic [23:0]        len_acc_next;

  rsfp_pkg::pos_t     pos_eff;
  rsfp_pkg::pos_t     target;
  logic [23:0]        acc_shift;
  logic [23:0]        acc_enter;
  logic [23:0]        cnt_inc;
  logic [23:0]        cnt_dec;
  logic [15:0]        flag_word;
  logic               enter_req;
  logic               flast;
  logic               frame_end;
  logic [1:0]         err;

  always_comb begin
    pos_eff               = parse_position;
    prefix_mode_next      = prefix_mode;
    parse_position_next   = parse_position;
    field_byte_count_next = field_byte_count;
    frame_bytes_left_next = frame_bytes_left;
    current_type_next     = current_type;
    resume_seen_next      = resume_seen;
    metadata_seen_next    = metadata_seen;
    len_acc_next          = len_acc;
    acc_shift             = {len_acc[15:0], item.data_byte};
    acc_enter             = len_acc;
    cnt_inc               = field_byte_count + 24'd1;
    cnt_dec               = (field_byte_count != '0) ? field_byte_count - 24'd1
                                                     : field_byte_count;
    flag_word             = {len_acc[7:0], item.data_byte};
    target                = rsfp_pkg::POS_DATA;
    enter_req             = 1'b0;
    flast                 = 1'b0;
    frame_end             = 1'b0;
    err                   = rsfp_pkg::ERR_NONE;

    // frame start: latch the prefix mode
    if (parse_position == rsfp_pkg::POS_LEN && field_byte_count == '0) begin
      prefix_mode_next = length_prefix_enable;
      if (!length_prefix_enable) pos_eff = rsfp_pkg::POS_STREAM;
    end

    if (pos_eff == rsfp_pkg::POS_LEN) begin
      field_byte_count_next = cnt_inc;
      len_acc_next          = acc_shift;
      if (cnt_inc >= rsfp_pkg::PREFIX_BYTES) begin
        flast                 = 1'b1;
        frame_bytes_left_next = acc_shift;
        len_acc_next          = '0;
        if (acc_shift == '0) begin
          frame_end = 1'b1;
          err       = rsfp_pkg::ERR_TRUNC;
        end else begin
          parse_position_next   = rsfp_pkg::POS_STREAM;
          field_byte_count_next = '0;
        end
      end
      if (item.end_of_capture) begin
        frame_end = 1'b1;
        err       = rsfp_pkg::ERR_PREFIX;
      end
    end else begin
      if (prefix_mode_next && frame_bytes_left != '0)
        frame_bytes_left_next = frame_bytes_left - 24'd1;
      frame_end = item.end_of_capture || (prefix_mode_next && frame_bytes_left_next == '0);

      if (pos_eff == rsfp_pkg::POS_DATA) begin
        parse_position_next = rsfp_pkg::POS_DATA;
      end else if (rsfp_pkg::is_body(pos_eff)) begin
        field_byte_count_next = cnt_dec;
        if (cnt_dec == '0) begin
          flast     = 1'b1;
          enter_req = 1'b1;
        end
      end else begin
        field_byte_count_next = cnt_inc;
        if (pos_eff == rsfp_pkg::POS_TYPE) begin
          if (cnt_inc == 24'd1) begin
            current_type_next = item.data_byte[7:2];
            acc_enter         = {16'd0, item.data_byte};
          end else begin
            metadata_seen_next = |(flag_word & rsfp_pkg::FLAG_METADATA);
            resume_seen_next   = |(flag_word & rsfp_pkg::FLAG_RESUME);
            acc_enter          = '0;
          end
        end else if (pos_eff == rsfp_pkg::POS_RTOK_LEN || pos_eff == rsfp_pkg::POS_MMIME_LEN ||
                     pos_eff == rsfp_pkg::POS_MD_LEN) begin
          acc_enter = acc_shift;
        end
        len_acc_next = acc_enter;
        if (cnt_inc >= {20'd0, rsfp_pkg::fixed_size(pos_eff)}) begin
          flast     = 1'b1;
          enter_req = 1'b1;
        end else begin
          parse_position_next = pos_eff;
        end
      end

      // move to the next field, a zero-length body is skipped
      if (enter_req) begin
        target = rsfp_pkg::next_of(pos_eff, current_type_next, metadata_seen_next,
                                   resume_seen_next);
        if (rsfp_pkg::is_body(target) && acc_enter == '0)
          target = rsfp_pkg::next_of(target, current_type_next, metadata_seen_next,
                                     resume_seen_next);
        parse_position_next   = target;
        field_byte_count_next = rsfp_pkg::is_body(target) ? acc_enter : '0;
        len_acc_next          = '0;
      end

      if (frame_end && pos_eff != rsfp_pkg::POS_DATA &&
          !(flast && parse_position_next == rsfp_pkg::POS_DATA))
        err = rsfp_pkg::ERR_TRUNC;
    end

    result.field_code = rsfp_pkg::pos_code(pos_eff);
    result.byte_out   = item.data_byte;
    result.frame_kind = current_type_next;
    result.field_last = frame_end || flast;
    result.frame_last = frame_end;
    result.fault_code = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_prefix_enable <= 1'b1;
    end else if (cfg_write_en) begin
      length_prefix_enable <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode      <= 1'b0;
      parse_position   <= rsfp_pkg::POS_LEN;
      field_byte_count <= '0;
      frame_bytes_left <= '0;
      current_type     <= '0;
      resume_seen      <= 1'b0;
      metadata_seen    <= 1'b0;
      len_acc          <= '0;
    end else if (step) begin
      if (frame_end) begin
        prefix_mode      <= 1'b0;
        parse_position   <= rsfp_pkg::POS_LEN;
        field_byte_count <= '0;
        frame_bytes_left <= '0;
        current_type     <= '0;
        resume_seen      <= 1'b0;
        metadata_seen    <= 1'b0;
        len_acc          <= '0;
      end else begin
        prefix_mode      <= prefix_mode_next;
        parse_position   <= parse_position_next;
        field_byte_count <= field_byte_count_next;
        frame_bytes_left <= frame_bytes_left_next;
        current_type     <= current_type_next;
        resume_seen      <= resume_seen_next;
        metadata_seen    <= metadata_seen_next;
        len_acc          <= len_acc_next;
      end
    end
  end

endmodule

// ===== rtl/rsfp_out_stage.sv =====
// rsfp_out_stage: result register of the frame parser, drives the output channel
// depends on rsfp_pkg and rsfp_field_if
module rsfp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rsfp_pkg::result_t  result,
  output logic               space,
  rsfp_field_if.source       field_tags
);

  logic               valid;
  rsfp_pkg::result_t  held;

  assign space = !valid || field_tags.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (field_tags.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign field_tags.valid      = valid;
  assign field_tags.field_code = held.field_code;
  assign field_tags.byte_out   = held.byte_out;
  assign field_tags.frame_kind = held.frame_kind;
  assign field_tags.field_last = held.field_last;
  assign field_tags.frame_last = held.frame_last;
  assign field_tags.fault_code = held.fault_code;

endmodule

// ===== rtl/reactive_stream_frame_parser_unit.sv =====
// reactive_stream_frame_parser_unit: byte-serial frame parser, top level
// depends on rsfp_pkg, rsfp_ifs, rsfp_in_stage, rsfp_field_engine, rsfp_out_stage
//
//   channel         dir   beat payload
//   raw_bytes       in    data_byte[7:0], end_of_capture
//   field_tags      out   field_code[4:0], byte_out[7:0], frame_kind[5:0],
//                         field_last, frame_last, fault_code[1:0]
//   cfg_write_*     in    length_prefix_enable (1 bit), no read-back
//
// one byte per cycle sustained while field_tags is ready; a beat taken into the input
// register is tagged by the combinational field engine and loaded into the result
// register once it has space, and shows on field_tags from there; the field engine
// holds the parse state between the input register and the result register
// rst (synchronous) clears all parse state and sets length_prefix_enable to 1
// a stalled field_tags holds its beat while one more byte waits in the input register
module reactive_stream_frame_parser_unit (
  input  logic          clk,
  input  logic          rst,
  rsfp_byte_if.sink     raw_bytes,
  rsfp_field_if.source  field_tags,
  input  logic          cfg_write_en,
  input  logic          cfg_write_data
);

  logic               hold_valid;
  logic               space;
  logic               take;
  rsfp_pkg::beat_t    item;
  rsfp_pkg::result_t  result;

  // a held byte is parsed whenever the result register can take its beat
  assign take = hold_valid && space;

  // input register
  rsfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .raw_bytes  (raw_bytes),
    .take       (take),
    .hold_valid (hold_valid),
    .item       (item)
  );

  // parse state, field tagging and the prefix-mode register
  rsfp_field_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .step           (take),
    .item           (item),
    .result         (result)
  );

  // result register
  rsfp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .result     (result),
    .space      (space),
    .field_tags (field_tags)
  );

`ifndef SYNTHESIS
  // an error is reported only on the last beat of a frame
  a_err_on_frame_last: assert property (@(posedge clk) disable iff (rst)
    field_tags.valid && field_tags.fault_code != rsfp_pkg::ERR_NONE |-> field_tags.frame_last)
    else $error("error code outside frame end");

  // frame end always closes the current field
  a_frame_closes_field: assert property (@(posedge clk) disable iff (rst)
    field_tags.valid && field_tags.frame_last |-> field_tags.field_last)
    else $error("frame_last without field_last");

  // a held byte is not dropped while the result register is full
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !space |=> hold_valid && $stable(item))
    else $error("held byte lost during output stall");
`endif

endmodule

// ===== dv/tb_reactive_stream_frame_parser_unit.sv =====
// tb_reactive_stream_frame_parser_unit: self-checking bench for the frame parser
// streams raw bytes with random gaps and backpressure, predicts every field tag beat
// depends on rsfp_pkg, rsfp_ifs and the parser rtl
`timescale 1ns / 100ps

module tb_reactive_stream_frame_parser_unit;

  bit   clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  rsfp_byte_if  raw_bytes();
  rsfp_field_if field_tags();

  reactive_stream_frame_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .raw_bytes     (raw_bytes),
    .field_tags    (field_tags),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // 4 ns clock, 2 ns high and 2 ns low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // field tags still owed by the dut, oldest first
  rsfp_pkg::result_t pending_tags[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  // 0 gives a stretch with no gaps on either side
  bit      idle_on = 1'b1;

  // ---------------------------------------------------------------------------
  // parser predictor: own copy of the register and of the frame state
  // ---------------------------------------------------------------------------
  logic        prefix_en;       // length_prefix_enable as last written
  logic [4:0]  cur_field;       // field the next byte belongs to
  logic [23:0] field_cnt;       // bytes seen in a fixed field, or left in a body
  logic [23:0] bytes_left;      // bytes of the declared length not yet seen
  logic [23:0] len_acc;         // length being assembled, big-endian
  logic [5:0]  cur_type;
  logic        resume_bit;
  logic        meta_flag;
  logic        frame_prefixed;  // prefix mode latched at the first byte of a frame

  function automatic void start_frame();
    cur_field      = rsfp_pkg::FC_LEN;
    field_cnt      = '0;
    bytes_left     = '0;
    len_acc        = '0;
    cur_type       = '0;
    resume_bit     = 1'b0;
    meta_flag      = 1'b0;
    frame_prefixed = 1'b0;
  endfunction

  // length-delimited fields
  function automatic logic body_field(input logic [4:0] f);
    return f == rsfp_pkg::FC_RTOK || f == rsfp_pkg::FC_MMIME ||
           f == rsfp_pkg::FC_DMIME || f == rsfp_pkg::FC_MD;
  endfunction

  function automatic int field_width(input logic [4:0] f);
    case (f)
      rsfp_pkg::FC_LEN, rsfp_pkg::FC_MD_LEN: return 3;
      rsfp_pkg::FC_STREAM, rsfp_pkg::FC_KEEPALIVE, rsfp_pkg::FC_LIFETIME,
      rsfp_pkg::FC_COUNT, rsfp_pkg::FC_ERRCODE: return 4;
      rsfp_pkg::FC_TYPE, rsfp_pkg::FC_MAJOR, rsfp_pkg::FC_MINOR,
      rsfp_pkg::FC_RTOK_LEN: return 2;
      rsfp_pkg::FC_MMIME_LEN, rsfp_pkg::FC_DMIME_LEN: return 1;
      rsfp_pkg::FC_POSITION: return 8;
      default: return 0;
    endcase
  endfunction

  // field order depends on the type and on the M and resume flags
  function automatic logic [4:0] follow_field(input logic [4:0] f);
    logic [4:0] tail;
    tail = meta_flag ? rsfp_pkg::FC_MD_LEN : rsfp_pkg::FC_DATA;
    case (f)
      rsfp_pkg::FC_LEN:       return rsfp_pkg::FC_STREAM;
      rsfp_pkg::FC_STREAM:    return rsfp_pkg::FC_TYPE;
      rsfp_pkg::FC_TYPE: begin
        if (cur_type == rsfp_pkg::T_SETUP) return rsfp_pkg::FC_MAJOR;
        if (cur_type == rsfp_pkg::T_KEEPALIVE) return rsfp_pkg::FC_POSITION;
        if (cur_type == rsfp_pkg::T_REQ_STREAM || cur_type == rsfp_pkg::T_REQ_CHANNEL ||
            cur_type == rsfp_pkg::T_REQ_N)
          return rsfp_pkg::FC_COUNT;
        if (cur_type == rsfp_pkg::T_ERROR) return rsfp_pkg::FC_ERRCODE;
        return tail;
      end
      rsfp_pkg::FC_MAJOR:     return rsfp_pkg::FC_MINOR;
      rsfp_pkg::FC_MINOR:     return rsfp_pkg::FC_KEEPALIVE;
      rsfp_pkg::FC_KEEPALIVE: return rsfp_pkg::FC_LIFETIME;
      rsfp_pkg::FC_LIFETIME:
        return resume_bit ? rsfp_pkg::FC_RTOK_LEN : rsfp_pkg::FC_MMIME_LEN;
      rsfp_pkg::FC_RTOK_LEN:  return rsfp_pkg::FC_RTOK;
      rsfp_pkg::FC_RTOK:      return rsfp_pkg::FC_MMIME_LEN;
      rsfp_pkg::FC_MMIME_LEN: return rsfp_pkg::FC_MMIME;
      rsfp_pkg::FC_MMIME:     return rsfp_pkg::FC_DMIME_LEN;
      rsfp_pkg::FC_DMIME_LEN: return rsfp_pkg::FC_DMIME;
      rsfp_pkg::FC_MD_LEN:    return rsfp_pkg::FC_MD;
      rsfp_pkg::FC_DMIME, rsfp_pkg::FC_POSITION, rsfp_pkg::FC_COUNT,
      rsfp_pkg::FC_ERRCODE:   return tail;
      default:                return rsfp_pkg::FC_DATA;
    endcase
  endfunction

  // move into a field; a body of length zero is skipped over
  function automatic void open_field(input logic [4:0] f_in);
    logic [4:0] f;
    f = f_in;
    while (body_field(f) && len_acc == 0) f = follow_field(f);
    cur_field = f;
    field_cnt = body_field(f) ? len_acc : 24'd0;
    len_acc   = '0;
  endfunction

  // tag of one accepted raw byte, advancing the predicted frame state
  function automatic rsfp_pkg::result_t predict_tag(input logic [7:0] b, input logic eoc);
    logic [4:0]        f;
    logic [4:0]        nxt;
    logic              flast;
    logic              fin;
    logic [1:0]        err;
    logic [15:0]       word;
    rsfp_pkg::result_t tag;
    f     = cur_field;
    nxt   = rsfp_pkg::FC_DATA;
    flast = 1'b0;
    fin   = 1'b0;
    err   = rsfp_pkg::ERR_NONE;
    // first byte of a frame latches the prefix mode
    if (f == rsfp_pkg::FC_LEN && field_cnt == 0) begin
      frame_prefixed = prefix_en;
      if (!frame_prefixed) f = rsfp_pkg::FC_STREAM;
    end
    if (f == rsfp_pkg::FC_LEN) begin
      len_acc   = {len_acc[15:0], b};
      field_cnt = field_cnt + 24'd1;
      if (field_cnt >= rsfp_pkg::PREFIX_BYTES) begin
        flast      = 1'b1;
        bytes_left = len_acc;
        len_acc    = '0;
        // declared length of zero: frame is over already
        if (bytes_left == 0) begin
          fin = 1'b1;
          err = rsfp_pkg::ERR_TRUNC;
        end else begin
          open_field(rsfp_pkg::FC_STREAM);
        end
      end
      // capture end inside the prefix wins over everything
      if (eoc) begin
        fin = 1'b1;
        err = rsfp_pkg::ERR_PREFIX;
      end
    end else begin
      if (frame_prefixed && bytes_left != 0) bytes_left = bytes_left - 24'd1;
      fin = eoc || (frame_prefixed && bytes_left == 0);
      if (f == rsfp_pkg::FC_DATA) begin
        cur_field = rsfp_pkg::FC_DATA;
      end else if (body_field(f)) begin
        if (field_cnt != 0) field_cnt = field_cnt - 24'd1;
        if (field_cnt == 0) begin
          flast = 1'b1;
          open_field(follow_field(f));
          nxt = cur_field;
        end
      end else begin
        field_cnt = field_cnt + 24'd1;
        if (f == rsfp_pkg::FC_TYPE) begin
          if (field_cnt == 1) begin
            cur_type = b[7:2];
            len_acc  = {16'd0, b};
          end else begin
            word       = {len_acc[7:0], b};
            meta_flag  = (word & rsfp_pkg::FLAG_METADATA) != 0;
            resume_bit = (word & rsfp_pkg::FLAG_RESUME) != 0;
            len_acc    = '0;
          end
        end else if (f == rsfp_pkg::FC_RTOK_LEN || f == rsfp_pkg::FC_MMIME_LEN ||
                     f == rsfp_pkg::FC_MD_LEN) begin
          len_acc = {len_acc[15:0], b};
        end
        if (field_cnt >= field_width(f)) begin
          flast = 1'b1;
          open_field(follow_field(f));
          nxt = cur_field;
        end else begin
          cur_field = f;
        end
      end
      // ending is clean only inside data or on the byte that completes the structure
      if (fin && f != rsfp_pkg::FC_DATA && !(flast && nxt == rsfp_pkg::FC_DATA))
        err = rsfp_pkg::ERR_TRUNC;
    end
    tag.field_code = f;
    tag.byte_out   = b;
    tag.frame_kind = cur_type;
    tag.field_last = fin | flast;
    tag.frame_last = fin;
    tag.fault_code = err;
    if (fin) start_frame();
    return tag;
  endfunction

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  // source gap in cycles: mostly none or short, now and then long
  function automatic int source_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // sink stall in cycles, never zero
  function automatic int sink_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // field_tags ready: changes at the falling edge only
  initial begin : tag_sink
    int n;
    field_tags.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = sink_stall();
        field_tags.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      field_tags.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking of every field tag beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : tag_check
    rsfp_pkg::result_t want;
    if (!rst && field_tags.valid === 1'b1 && field_tags.ready === 1'b1) begin
      if (pending_tags.size() == 0) begin
        $error("field_tags beat with nothing expected, byte_out %0d", field_tags.byte_out);
        mismatches++;
      end else begin
        want = pending_tags.pop_front();
        check_field("field_code", 8'(want.field_code), 8'(field_tags.field_code));
        check_field("byte_out", want.byte_out, field_tags.byte_out);
        check_field("frame_kind", 8'(want.frame_kind), 8'(field_tags.frame_kind));
        check_field("field_last", 8'(want.field_last), 8'(field_tags.field_last));
        check_field("frame_last", 8'(want.frame_last), 8'(field_tags.frame_last));
        check_field("fault_code", 8'(want.fault_code), 8'(field_tags.fault_code));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // one raw byte beat; returns just after the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic eoc);
    int gap;
    gap = source_gap();
    @(negedge clk);
    if (gap > 0) begin
      raw_bytes.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_bytes.valid          <= 1'b1;
    raw_bytes.data_byte      <= b;
    raw_bytes.end_of_capture <= eoc;
    do @(posedge clk); while (raw_bytes.ready !== 1'b1);
    pending_tags.push_back(predict_tag(b, eoc));
    bytes_sent++;
  endtask

  // drop valid and let every owed tag come out, plus the pipeline depth
  task automatic wait_results();
    @(negedge clk);
    raw_bytes.valid <= 1'b0;
    while (pending_tags.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only with the parser drained
  task automatic set_prefix_mode(input logic en);
    wait_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= en;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    prefix_en = en;
  endtask

  // frame body under construction, without the length prefix
  logic [7:0] frame_buf[$];

  function automatic void push_random(input int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
  endfunction

  // big-endian length field followed by its body
  function automatic void push_counted(input int n, input int len_bytes);
    for (int i = len_bytes - 1; i >= 0; i--) frame_buf.push_back(8'(n >> (8 * i)));
    push_random(n);
  endfunction

  // body length: often empty, mostly short, rarely the largest allowed here
  function automatic int body_len(input int cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 98) return $urandom_range(7, 40);
    return cap;
  endfunction

  // one random frame, mostly well formed, sometimes cut short or plain noise
  task automatic send_random_frame();
    logic [5:0] ftype;
    logic       meta;
    logic       resume;
    logic       eoc_at_stop;
    int         kind;
    int         stop_at;
    int         declared;
    int         n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise, always closed by a capture end so the next frame starts clean
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), i == n - 1 || $urandom_range(0, 7) == 0);
    end else begin
      case ($urandom_range(0, 7))
        0, 1:    ftype = rsfp_pkg::T_SETUP;
        2:       ftype = rsfp_pkg::T_KEEPALIVE;
        3:       ftype = rsfp_pkg::T_REQ_STREAM;
        4:       ftype = rsfp_pkg::T_REQ_CHANNEL;
        5:       ftype = rsfp_pkg::T_REQ_N;
        6:       ftype = rsfp_pkg::T_ERROR;
        default: ftype = 6'($urandom_range(0, 63));
      endcase
      meta   = $urandom_range(0, 2) == 0;
      resume = 1'($urandom_range(0, 1));
      frame_buf.delete();
      push_random(4);
      // type/flags word: type in the top six bits, M flag in bit 8, resume in bit 7
      frame_buf.push_back({ftype, 1'($urandom_range(0, 1)), meta});
      frame_buf.push_back({resume, 7'($urandom)});
      if (ftype == rsfp_pkg::T_SETUP) begin
        push_random(12);
        if (resume) push_counted(body_len(300), 2);
        push_counted(body_len(255), 1);
        push_counted(body_len(255), 1);
      end else if (ftype == rsfp_pkg::T_KEEPALIVE) begin
        push_random(8);
      end else if (ftype == rsfp_pkg::T_REQ_STREAM || ftype == rsfp_pkg::T_REQ_CHANNEL ||
                   ftype == rsfp_pkg::T_REQ_N || ftype == rsfp_pkg::T_ERROR) begin
        push_random(4);
      end
      if (meta) push_counted(body_len(300), 3);
      push_random($urandom_range(0, 8));

      stop_at  = frame_buf.size() - 1;
      declared = frame_buf.size();
      eoc_at_stop = !prefix_en || $urandom_range(0, 1);
      if (kind == 1) begin
        // short declared length, or capture end early without the prefix
        stop_at  = $urandom_range(0, frame_buf.size() - 2);
        declared = stop_at + 1;
      end else if (kind == 2) begin
        // capture ends before the declared length runs out
        stop_at     = $urandom_range(0, frame_buf.size() - 2);
        eoc_at_stop = 1'b1;
      end
      if (prefix_en)
        for (int i = 2; i >= 0; i--) send_byte(8'(declared >> (8 * i)), 1'b0);
      for (int i = 0; i <= stop_at; i++)
        send_byte(frame_buf[i], i == stop_at && eoc_at_stop);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // zero declared length, capture end on the first and on the last prefix byte
  task automatic test_prefix_edge_cases();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b1);
    wait_results();
  endtask

  // register change in the middle of a frame only counts from the next frame
  task automatic test_config_mid_frame();
    set_prefix_mode(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    set_prefix_mode(1'b0);
    // frame still runs on its declared length and ends inside the stream id
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    // new frame without prefix, cut off in the stream id
    send_byte(8'h81, 1'b1);
    wait_results();
  endtask

  // all-ones and all-zeros bytes without the prefix
  task automatic test_no_prefix_extremes();
    set_prefix_mode(1'b0);
    // type 63 with the M flag, ends before the metadata length
    for (int i = 0; i < 6; i++) send_byte(8'hFF, i == 5);
    // type 0, no flags, one data byte closes cleanly
    for (int i = 0; i < 7; i++) send_byte(8'h00, i == 6);
    wait_results();
  endtask

  // random frames in phases, alternating the prefix mode
  task automatic test_random_frames();
    int phase_start;
    for (int phase = 0; phase < 6; phase++) begin
      set_prefix_mode(phase % 2 == 1);
      idle_on     = (phase != 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 125) send_random_frame();
    end
    idle_on = 1'b1;
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                      = 1'b1;
    cfg_write_en             = 1'b0;
    cfg_write_data           = 1'b0;
    raw_bytes.valid          = 1'b0;
    raw_bytes.data_byte      = 8'h00;
    raw_bytes.end_of_capture = 1'b0;
    // register comes out of reset with the prefix on
    prefix_en = 1'b1;
    start_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_prefix_edge_cases();
    test_config_mid_frame();
    test_no_prefix_extremes();
    test_random_frames();

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== reactive_stream_frame_parser_unit.f =====
rtl/rsfp_pkg.sv
rtl/rsfp_ifs.sv
rtl/rsfp_in_stage.sv
rtl/rsfp_field_engine.sv
rtl/rsfp_out_stage.sv
rtl/reactive_stream_frame_parser_unit.sv
dv/tb_reactive_stream_frame_parser_unit.sv
